### src/cian_pkg.sv
// Shared types, widths and helper functions for the collision impulse pipeline.
`default_nettype none
package cian_pkg;

  localparam int unsigned VelW = 32;
  localparam int unsigned NrmW = 16;
  localparam int unsigned MassW = 32;
  localparam int unsigned BncW = 16;
  localparam int unsigned RatW = 31;
  localparam int unsigned QuoW = 31;
  localparam int unsigned DivSteps = 31;

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_INF_A = 2'd1,
    MODE_INF_B = 2'd2,
    MODE_FINITE = 2'd3
  } mode_t;

  typedef struct packed {
    logic [MassW:0] den;
    logic [MassW+1:0] rem;
    logic [QuoW-1:0] quo;
    logic signed [VelW-1:0] pa;
    logic signed [VelW-1:0] pb;
    logic signed [NrmW-1:0] nx;
    logic signed [NrmW-1:0] ny;
    logic [BncW:0] bsum;
    mode_t mode;
    logic zero;
    logic sat;
  } div_cell_t;

  function automatic logic signed [VelW-1:0] sat32(input logic signed [63:0] x,
                                                  output logic flag);
    begin
      flag = 1'b0;
      if (x > 64'sd2147483647) begin
        flag = 1'b1;
        sat32 = 32'sh7FFFFFFF;
      end else if (x < -64'sd2147483648) begin
        flag = 1'b1;
        sat32 = 32'sh80000000;
      end else begin
        sat32 = x[VelW-1:0];
      end
    end
  endfunction

endpackage
`default_nettype wire

### src/cian_div_cell.sv
// One restoring-division step cell that also carries the item along the chain.
`default_nettype none
module cian_div_cell (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic valid_in,
  input  wire logic num_bit,
  input  cian_pkg::div_cell_t cell_in,
  output logic valid_out,
  output cian_pkg::div_cell_t cell_out
);
  cian_pkg::div_cell_t cell_next;
  logic [cian_pkg::MassW+1:0] shifted;
  logic [cian_pkg::MassW+1:0] trial;

  always_comb begin
    cell_next = cell_in;
    shifted = {cell_in.rem[cian_pkg::MassW:0], num_bit};
    trial = shifted - {1'b0, cell_in.den};
    if (!trial[cian_pkg::MassW+1]) begin
      cell_next.rem = trial;
      cell_next.quo = {cell_in.quo[cian_pkg::QuoW-2:0], 1'b1};
    end else begin
      cell_next.rem = shifted;
      cell_next.quo = {cell_in.quo[cian_pkg::QuoW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
    cell_out <= cell_next;
  end
endmodule
`default_nettype wire

### src/collision_impulse_along_normal_top.sv
// Top level of the collision impulse pipeline: projection, division chain and output scaling.
// Throughput: one request per cycle; busy is always low, the pipeline never stalls.
// The ratio mass_a / (mass_a + mass_b) comes from a chain of 31 one-bit divider cells.
// Synchronous reset clears all valid bits; payload registers are not reset.
`default_nettype none
module collision_impulse_along_normal_top (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic busy,
  input  wire logic [31:0] mass_a,
  input  wire logic mass_a_infinite,
  input  wire logic [31:0] mass_b,
  input  wire logic mass_b_infinite,
  input  wire logic signed [31:0] vel_a_x,
  input  wire logic signed [31:0] vel_a_y,
  input  wire logic signed [31:0] vel_b_x,
  input  wire logic signed [31:0] vel_b_y,
  input  wire logic signed [15:0] normal_x,
  input  wire logic signed [15:0] normal_y,
  input  wire logic [15:0] bounce_a,
  input  wire logic [15:0] bounce_b,
  output logic done,
  output logic signed [31:0] delta_a_x,
  output logic signed [31:0] delta_a_y,
  output logic signed [31:0] delta_b_x,
  output logic signed [31:0] delta_b_y,
  output logic mass_sum_zero,
  output logic saturated
);
  localparam int unsigned N = cian_pkg::DivSteps;

  // Stage 1: products.
  logic v1;
  logic signed [47:0] p_ax, p_ay, p_bx, p_by;
  logic [32:0] m1;
  logic [31:0] ma1;
  cian_pkg::mode_t mode1;
  logic signed [15:0] nx1, ny1;
  logic [16:0] bs1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else v1 <= start;
    p_ax <= vel_a_x * normal_x;
    p_ay <= vel_a_y * normal_y;
    p_bx <= vel_b_x * normal_x;
    p_by <= vel_b_y * normal_y;
    m1 <= {1'b0, mass_a} + {1'b0, mass_b};
    ma1 <= mass_a;
    mode1 <= mass_a_infinite ? (mass_b_infinite ? cian_pkg::MODE_NONE : cian_pkg::MODE_INF_A)
                             : (mass_b_infinite ? cian_pkg::MODE_INF_B : cian_pkg::MODE_FINITE);
    nx1 <= normal_x;
    ny1 <= normal_y;
    bs1 <= {1'b0, bounce_a} + {1'b0, bounce_b};
  end

  // Stage 2: projection and divider setup. Numerator is ma*2^30 + M/2.
  logic signed [63:0] sa, sb;
  logic fa, fb;
  logic signed [31:0] pa2, pb2;
  logic [63:0] num;
  logic [63:0] q_hi;
  logic [32:0] r_hi;
  cian_pkg::div_cell_t c0;
  logic v2;

  always_comb begin
    sa = ((64'(p_ax) + 64'(p_ay)) + 64'sd8192) >>> 14;
    sb = ((64'(p_bx) + 64'(p_by)) + 64'sd8192) >>> 14;
    pa2 = cian_pkg::sat32(sa, fa);
    pb2 = cian_pkg::sat32(sb, fb);
    num = ({32'd0, ma1} << 30) + {32'd0, m1[32:1]};
    // The top 33 bits never exceed the divisor range usage: quotient high part is 0 or 1.
    q_hi = num >> N;
    r_hi = 33'd0;
    c0 = '0;
    c0.den = m1;
    c0.rem = (q_hi[33:0] >= {1'b0, m1}) ? (q_hi[33:0] - {1'b0, m1}) : q_hi[33:0];
    r_hi = 33'(q_hi >= {31'd0, m1});
    c0.quo = {{(cian_pkg::QuoW-1){1'b0}}, r_hi[0]};
    c0.pa = pa2;
    c0.pb = pb2;
    c0.nx = nx1;
    c0.ny = ny1;
    c0.bsum = bs1;
    c0.mode = mode1;
    c0.zero = (mode1 == cian_pkg::MODE_FINITE) && (m1 == 33'd0);
    c0.sat = fa | fb;
  end

  // Low bits of numerator travel with the chain.
  logic [N-1:0] low_bits [N+1];
  cian_pkg::div_cell_t cs [N+1];
  logic vs [N+1];

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else v2 <= v1;
    cs[0] <= c0;
    low_bits[0] <= num[N-1:0];
  end
  assign vs[0] = v2;

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_div
      cian_div_cell u_cell (
        .clk(clk), .rst(rst), .valid_in(vs[g]), .num_bit(low_bits[g][N-1-g]),
        .cell_in(cs[g]), .valid_out(vs[g+1]), .cell_out(cs[g+1])
      );
      always_ff @(posedge clk) low_bits[g+1] <= low_bits[g];
    end
  endgenerate

  // Quotient assembly: the ratio is the quotient bits of the chain cells; the high bit from setup is shifted out.
  logic signed [31:0] rat;
  cian_pkg::div_cell_t ce;
  assign ce = cs[N];
  assign rat = {1'b0, ce.quo};

  // Stage A: diff * r.
  logic va;
  logic signed [63:0] prod_a;
  logic signed [33:0] diff_a;
  cian_pkg::div_cell_t ca;
  always_ff @(posedge clk) begin
    if (rst) va <= 1'b0;
    else va <= vs[N];
    prod_a <= (34'(ce.pa) - 34'(ce.pb)) * rat;
    diff_a <= 34'(ce.pa) - 34'(ce.pb);
    ca <= ce;
  end

  // Stage B: select base deltas.
  logic vb;
  logic signed [35:0] da_b, db_b;
  cian_pkg::div_cell_t cb;
  logic signed [63:0] dbf;
  always_comb dbf = (prod_a + 64'sd268435456) >>> 29;
  always_ff @(posedge clk) begin
    if (rst) vb <= 1'b0;
    else vb <= va;
    cb <= ca;
    unique case (ca.mode)
      cian_pkg::MODE_FINITE: begin
        db_b <= dbf[35:0];
        da_b <= dbf[35:0] - 36'(diff_a <<< 1);
      end
      cian_pkg::MODE_INF_A: begin
        da_b <= '0;
        db_b <= -(36'(ca.pb) <<< 1);
      end
      cian_pkg::MODE_INF_B: begin
        da_b <= -(36'(ca.pa) <<< 1);
        db_b <= '0;
      end
      default: begin
        da_b <= '0;
        db_b <= '0;
      end
    endcase
  end

  // Stage C: bounce scaling.
  logic vc;
  logic signed [53:0] ma_c, mb_c;
  cian_pkg::div_cell_t cc;
  always_ff @(posedge clk) begin
    if (rst) vc <= 1'b0;
    else vc <= vb;
    ma_c <= da_b * $signed({1'b0, cb.bsum});
    mb_c <= db_b * $signed({1'b0, cb.bsum});
    cc <= cb;
  end

  // Stage D: rounding of scaled deltas.
  logic vd;
  logic signed [37:0] da_d, db_d;
  cian_pkg::div_cell_t cd;
  always_ff @(posedge clk) begin
    if (rst) vd <= 1'b0;
    else vd <= vc;
    da_d <= 38'((ma_c + 54'sd32768) >>> 16);
    db_d <= 38'((mb_c + 54'sd32768) >>> 16);
    cd <= cc;
  end

  // Stage E: multiply by the normal.
  logic ve;
  logic signed [53:0] ax_e, ay_e, bx_e, by_e;
  cian_pkg::div_cell_t ce2;
  always_ff @(posedge clk) begin
    if (rst) ve <= 1'b0;
    else ve <= vd;
    ax_e <= da_d * cd.nx;
    ay_e <= da_d * cd.ny;
    bx_e <= db_d * cd.nx;
    by_e <= db_d * cd.ny;
    ce2 <= cd;
  end

  // Stage F: round, saturate, output register.
  logic fx0, fx1, fx2, fx3;
  logic signed [31:0] ox0, ox1, ox2, ox3;
  logic kill;
  always_comb begin
    ox0 = cian_pkg::sat32(64'((ax_e + 54'sd8192) >>> 14), fx0);
    ox1 = cian_pkg::sat32(64'((ay_e + 54'sd8192) >>> 14), fx1);
    ox2 = cian_pkg::sat32(64'((bx_e + 54'sd8192) >>> 14), fx2);
    ox3 = cian_pkg::sat32(64'((by_e + 54'sd8192) >>> 14), fx3);
    kill = (ce2.mode == cian_pkg::MODE_NONE) || ce2.zero;
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= ve;
    delta_a_x <= kill ? '0 : ox0;
    delta_a_y <= kill ? '0 : ox1;
    delta_b_x <= kill ? '0 : ox2;
    delta_b_y <= kill ? '0 : ox3;
    mass_sum_zero <= ce2.zero;
    saturated <= kill ? 1'b0 : (ce2.sat | fx0 | fx1 | fx2 | fx3);
  end

  assign busy = 1'b0;
endmodule
`default_nettype wire
